// ----- rtl/core/rsu_pkg.sv -----
// ----------------------------------------------------------------------------
// rsu_pkg - shared types and constants for the radix string parser
// Status codes, register indexes, field widths and the queue entry format
// used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package rsu_pkg;

   // Field widths fixed by the channel definitions
   localparam int CHAR_WIDTH      = 8;
   localparam int RADIX_WIDTH     = 6;
   localparam int DIGIT_WIDTH     = 6;
   localparam int VALUE_WIDTH     = 64;
   localparam int STATUS_WIDTH    = 3;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 8;

   // Decoupling queue depth between front and back, 2 or more
   localparam int QUEUE_DEPTH = 2;

   // Register reset values and the legal base range
   localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 6'd10;
   localparam logic                   WIDE_RESET  = 1'b1;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 6'd36;

   // Result limits for narrow and wide mode
   localparam logic [VALUE_WIDTH-1:0] LIMIT_NARROW = 64'h0000_0000_FFFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] LIMIT_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;

   // Register indexes on the CSR channel
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIX     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WIDE_MODE = 8'd1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_BASE  = 3'd1,
      STATUS_NON_ALNUM = 3'd2,
      STATUS_BAD_DIGIT = 3'd3,
      STATUS_OVERFLOW  = 3'd4
   } rsu_status_type;

   // One classified character, as it travels from front to back
   typedef struct packed {
      logic [DIGIT_WIDTH-1:0] digit;
      logic [RADIX_WIDTH-1:0] base;
      logic                   wide;
      rsu_status_type         err;
      logic                   last;
   } rsu_op_type;

   // Valid-qualified entry between stages
   typedef struct packed {
      logic       valid;
      rsu_op_type op;
   } rsu_entry_type;

endpackage

// ----- rtl/core/rsu_req_if.sv -----
// ----------------------------------------------------------------------------
// rsu_req_if - character request channel
// Carries one ASCII character per beat and a flag for the last character.
// ----------------------------------------------------------------------------
interface rsu_req_if
   import rsu_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/core/rsu_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rsu_rsp_if - result channel
// Carries the parsed value and its status, one beat per string.
// ----------------------------------------------------------------------------
interface rsu_rsp_if
   import rsu_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [VALUE_WIDTH-1:0]  value;
   logic [STATUS_WIDTH-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- rtl/core/rsu_csr_if.sv -----
// ----------------------------------------------------------------------------
// rsu_csr_if - register write channel
// Carries a register index and write data, one register per beat.
// ----------------------------------------------------------------------------
interface rsu_csr_if
   import rsu_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/rsu_front.sv -----
// ----------------------------------------------------------------------------
// rsu_front - character classifier and register file
// Holds radix and mode, decodes each accepted character into a digit value
// and an early error class, and pushes the result into the queue.
// ----------------------------------------------------------------------------
module rsu_front
   import rsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   rsu_req_if.sink       req_bus,
   rsu_csr_if.sink       csr_bus,
   output rsu_entry_type push,
   input  logic          push_ready
);

   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   wide_ff, wide_in;

   logic [DIGIT_WIDTH-1:0] digit;
   logic                   is_alnum;
   logic                   base_bad;
   rsu_status_type         err;

   // Register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      wide_in  = wide_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_RADIX:     radix_in = csr_bus.data[RADIX_WIDTH-1:0];
            CSR_WIDE_MODE: wide_in  = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         wide_ff  <= WIDE_RESET;
      end else begin
         radix_ff <= radix_in;
         wide_ff  <= wide_in;
      end
   end

   // Digit decode: 0-9, then A-Z and a-z as 10 to 35
   always_comb begin
      digit    = '0;
      is_alnum = 1'b1;
      if (req_bus.char_code >= 8'h30 && req_bus.char_code <= 8'h39) begin
         digit = DIGIT_WIDTH'(req_bus.char_code - 8'h30);
      end else if (req_bus.char_code >= 8'h41 && req_bus.char_code <= 8'h5A) begin
         digit = DIGIT_WIDTH'(req_bus.char_code - 8'h37);
      end else if (req_bus.char_code >= 8'h61 && req_bus.char_code <= 8'h7A) begin
         digit = DIGIT_WIDTH'(req_bus.char_code - 8'h57);
      end else begin
         is_alnum = 1'b0;
      end
   end

   // Early error class; bad base wins over the character itself
   assign base_bad = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);

   always_comb begin
      if (base_bad) begin
         err = STATUS_BAD_BASE;
      end else if (!is_alnum) begin
         err = STATUS_NON_ALNUM;
      end else if (digit >= radix_ff) begin
         err = STATUS_BAD_DIGIT;
      end else begin
         err = STATUS_OK;
      end
   end

   // Push towards the queue
   assign req_bus.ready  = push_ready;
   assign push.valid     = req_bus.valid;
   assign push.op.digit  = digit;
   assign push.op.base   = radix_ff;
   assign push.op.wide   = wide_ff;
   assign push.op.err    = err;
   assign push.op.last   = req_bus.last_char;

endmodule

// ----- rtl/core/rsu_queue.sv -----
// ----------------------------------------------------------------------------
// rsu_queue - decoupling queue between front and back
// Small register FIFO of classified characters; ready depends on fill only.
// ----------------------------------------------------------------------------
module rsu_queue
   import rsu_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  rsu_entry_type push,
   output logic          push_ready,
   output rsu_entry_type head,
   input  logic          pop
);

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);

   rsu_op_type              slot_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != CountFull);
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && head.valid;

   assign head.valid = (count_ff != '0);
   assign head.op    = slot_ff[rd_ptr_ff];

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

// ----- rtl/core/rsu_back.sv -----
// ----------------------------------------------------------------------------
// rsu_back - accumulator and result stage
// Applies one classified character per cycle (a last one waits on a held result):
// multiply-add with overflow check, first-error tracking, and the registered result beat.
// ----------------------------------------------------------------------------
module rsu_back
   import rsu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  rsu_entry_type head,
   output logic          pop,
   rsu_rsp_if.source     rsp_bus
);

   localparam int ProdWidth = VALUE_WIDTH + RADIX_WIDTH;

   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   rsu_status_type          err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff, rsp_value_in;
   rsu_status_type          rsp_status_ff, rsp_status_in;

   logic [ProdWidth-1:0]    prod;
   logic [ProdWidth:0]      sum;
   logic [VALUE_WIDTH-1:0]  limit;
   logic                    ovf;
   logic [VALUE_WIDTH-1:0]  acc_step;
   rsu_status_type          err_step;

   // Last beats need the output register free; others go straight through
   assign pop = head.valid && (!head.op.last || !rsp_valid_ff || rsp_bus.ready);

   // Multiply-add and compare against the mode limit
   assign prod  = ProdWidth'(acc_ff) * ProdWidth'(head.op.base);
   assign sum   = {1'b0, prod} + (ProdWidth + 1)'(head.op.digit);
   assign limit = head.op.wide ? LIMIT_WIDE : LIMIT_NARROW;
   assign ovf   = sum > (ProdWidth + 1)'(limit);

   // Character step; a recorded error freezes the string
   always_comb begin
      acc_step = acc_ff;
      err_step = err_ff;
      if (err_ff == STATUS_OK) begin
         if (head.op.err != STATUS_OK) begin
            err_step = head.op.err;
         end else if (ovf) begin
            err_step = STATUS_OVERFLOW;
         end else begin
            acc_step = sum[VALUE_WIDTH-1:0];
         end
      end
   end

   // State and result register update
   always_comb begin
      acc_in        = acc_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (pop) begin
         if (head.op.last) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = (err_step == STATUS_OK) ? acc_step : '0;
            rsp_status_in = err_step;
            acc_in        = '0;
            err_in        = STATUS_OK;
         end else begin
            acc_in = acc_step;
            err_in = err_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

endmodule

// ----- rtl/core/radix_string_to_unsigned.sv -----
// ----------------------------------------------------------------------------
// radix_string_to_unsigned - ASCII digit string to unsigned number
// Parses one character per beat in a programmable radix of 2 to 36 and
// returns the value and a status when the last character has been taken.
//
//   channel  | dir | beat contents             | accepted when
//   ---------+-----+---------------------------+--------------------
//   req_bus  | in  | char_code, last_char      | valid && ready
//   rsp_bus  | out | value, status             | valid && ready
//   csr_bus  | in  | index, data               | valid (ready tied high)
//
// One character per cycle sustained while results are taken; the rate is set
// by the combinational multiply-add and limit compare on the accumulator in
// the back end. A result passes through the queue slot and then the result
// register after its last character beat is accepted; the result register is
// written once the back end takes that entry and the register is free.
// Synchronous reset empties the queue, clears the accumulator and error,
// and restores radix 10 and wide mode; no clearing pass is needed.
// A stalled result holds; characters keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module radix_string_to_unsigned
   import rsu_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   rsu_req_if.sink   req_bus,
   rsu_rsp_if.source rsp_bus,
   rsu_csr_if.sink   csr_bus
);

   rsu_entry_type push;
   rsu_entry_type head;
   logic          push_ready;
   logic          pop;

   // Classify characters and hold the registers
   rsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   // Decouple front and back
   rsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // Accumulate and deliver results
   rsu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- rtl/core/rsu_checker.sv -----
// ----------------------------------------------------------------------------
// rsu_checker - port-level assertions for the radix string parser
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
module rsu_checker
   import rsu_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [VALUE_WIDTH-1:0]  rsp_value,
   input logic [STATUS_WIDTH-1:0] rsp_status
);

   // A stalled result beat holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // Any failing status comes with a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_value == '0)
      else $error("non-zero value with error status");

   // Queue is empty and open straight after reset
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("request channel not ready after reset");

   // No result beat straight after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");

endmodule

bind radix_string_to_unsigned rsu_checker u_rsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_status (rsp_bus.status)
);
